// File: rtl/cpt_pkg.sv
// Shared types and constants for the copy propagation table.
// Holds the channel words, the lane command, query and status records.
// No dependencies.
package cpt_pkg;

   // Register index width as carried by the instruction words.
   localparam int REG_W = 8;

   // Table entries beyond this count can never be addressed by a field.
   localparam int MAX_LANES = 1 << REG_W;

   // Instruction part kinds.
   localparam logic KIND_OP   = 1'b0;
   localparam logic KIND_MOVE = 1'b1;

   typedef logic [REG_W-1:0] reg_idx_type;

   // One incoming instruction part.
   typedef struct packed {
      logic        kind;
      logic        block_start;
      logic [1:0]  src_count;
      reg_idx_type src_a;
      reg_idx_type src_b;
      reg_idx_type src_c;
      logic        has_dst;
      reg_idx_type dst_reg;
      logic        last_part;
   } req_word_type;

   // One rewritten instruction part.
   typedef struct packed {
      reg_idx_type res_a;
      reg_idx_type res_b;
      reg_idx_type res_c;
      logic        drop;
   } rsp_word_type;

   // Lookup request broadcast to every lane.
   typedef struct packed {
      logic        flush;
      reg_idx_type src_a;
      reg_idx_type src_b;
      reg_idx_type src_c;
   } lane_query_type;

   // Table update broadcast to every lane, only asserted on an accepted word.
   typedef struct packed {
      logic        clear;
      logic        kill_en;
      reg_idx_type kill_reg;
      logic        write_en;
      reg_idx_type write_reg;
      reg_idx_type write_origin;
   } lane_cmd_type;

   // What one lane reports back for the current lookup.
   typedef struct packed {
      logic        hit_a;
      logic        hit_b;
      logic        hit_c;
      reg_idx_type origin;
   } lane_status_type;

endpackage

// File: rtl/cpt_channels.sv
// Valid/ready channel interfaces for the copy propagation table.
// Depends on cpt_pkg for the word types.
interface cpt_req_if;
   import cpt_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cpt_rsp_if;
   import cpt_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/cpt_lane.sv
// One entry of the copy table: valid bit, origin register and match logic.
// Depends on cpt_pkg for the query, command and status records.
module cpt_lane #(
   parameter int LANE_IDX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cpt_pkg::lane_query_type   query,
   input  cpt_pkg::lane_cmd_type     cmd,
   output cpt_pkg::lane_status_type  status
);
   import cpt_pkg::*;

   localparam reg_idx_type IDX = LANE_IDX[REG_W-1:0];

   logic        valid_ff;
   logic        valid_in;
   reg_idx_type origin_ff;
   reg_idx_type origin_in;
   logic        live;
   logic        killed;

   // A block start empties the table before the lookup sees it.
   assign live = valid_ff && !query.flush;

   always_comb begin
      status.hit_a  = live && (query.src_a == IDX);
      status.hit_b  = live && (query.src_b == IDX);
      status.hit_c  = live && (query.src_c == IDX);
      status.origin = origin_ff;
   end

   // Writing a register removes its own entry and every entry copying it.
   assign killed = cmd.kill_en && ((origin_ff == cmd.kill_reg) || (IDX == cmd.kill_reg));

   always_comb begin
      valid_in  = valid_ff;
      origin_in = origin_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end
      if (killed) begin
         valid_in = 1'b0;
      end
      if (cmd.write_en && (cmd.write_reg == IDX)) begin
         valid_in  = 1'b1;
         origin_in = cmd.write_origin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      origin_ff <= origin_in;
   end

endmodule

// File: rtl/cpt_merge.sv
// Merging stage: folds the lane hits into the three resolved sources.
// Depends on cpt_pkg for the lane status record.
module cpt_merge #(
   parameter int LANES = 256
) (
   input  cpt_pkg::lane_status_type status [LANES],
   input  cpt_pkg::lane_query_type  query,
   output cpt_pkg::reg_idx_type     resolved_a,
   output cpt_pkg::reg_idx_type     resolved_b,
   output cpt_pkg::reg_idx_type     resolved_c
);
   import cpt_pkg::*;

   reg_idx_type or_a;
   reg_idx_type or_b;
   reg_idx_type or_c;
   logic        any_a;
   logic        any_b;
   logic        any_c;

   // At most one lane matches each source, so an OR of the masked
   // origins selects the matching one.
   always_comb begin
      or_a  = '0;
      or_b  = '0;
      or_c  = '0;
      any_a = 1'b0;
      any_b = 1'b0;
      any_c = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         or_a  = or_a | ({REG_W{status[i].hit_a}} & status[i].origin);
         or_b  = or_b | ({REG_W{status[i].hit_b}} & status[i].origin);
         or_c  = or_c | ({REG_W{status[i].hit_c}} & status[i].origin);
         any_a = any_a | status[i].hit_a;
         any_b = any_b | status[i].hit_b;
         any_c = any_c | status[i].hit_c;
      end
   end

   // A register without an entry resolves to itself.
   assign resolved_a = any_a ? or_a : query.src_a;
   assign resolved_b = any_b ? or_b : query.src_b;
   assign resolved_c = any_c ? or_c : query.src_c;

endmodule

// File: rtl/copy_propagation_table.sv
// Top level of the copy propagation table: lanes, merge and output register.
// Depends on cpt_pkg, cpt_channels, cpt_lane and cpt_merge.
//
// Usage: instruction parts arrive as words on req_ch and rewritten parts
// leave as words on rsp_ch, one result word for every accepted word, in
// order. Each word's sources are replaced by the registers they copy, and
// a move that became trivial is flagged with drop.
// Output: the result of an accepted word is registered and shows on rsp_ch
// in the cycle after the accept.
// Throughput: one word per cycle while rsp_ch is not stalled. The table lookup, the invalidation
// compare in every lane and the table update all fit in the cycle of the
// accept, so the next word sees the updated table at once.
// Stall: the output register holds its word while rsp_ch.ready is low;
// req_ch.ready follows it, so a new word is taken in the same cycle as the
// held one leaves.
// Reset: synchronous and active high; the table is empty and no result is
// pending once it is released. The table is cleared again at block start.
module copy_propagation_table #(
   parameter int NUM_REGS = 256
) (
   input  logic       clock,
   input  logic       reset,
   cpt_req_if.sink    req_ch,
   cpt_rsp_if.source  rsp_ch
);
   import cpt_pkg::*;

   localparam int LANES = (NUM_REGS < MAX_LANES) ? NUM_REGS : MAX_LANES;

   req_word_type    word;
   lane_query_type  query;
   lane_cmd_type    cmd;
   lane_status_type lane_status [LANES];
   reg_idx_type     resolved_a;
   reg_idx_type     resolved_b;
   reg_idx_type     resolved_c;
   logic            req_fire;
   logic            is_move;
   rsp_word_type    rsp_word;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_word_type    rsp_data_ff;
   rsp_word_type    rsp_data_in;

   assign word     = req_ch.data;
   assign is_move  = (word.kind == KIND_MOVE);
   assign req_fire = req_ch.valid && req_ch.ready;

   // Lookup request for every lane.
   always_comb begin
      query.flush = word.block_start;
      query.src_a = word.src_a;
      query.src_b = word.src_b;
      query.src_c = word.src_c;
   end

   // One table entry per lane.
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      cpt_lane #(
         .LANE_IDX (g)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .query  (query),
         .cmd    (cmd),
         .status (lane_status[g])
      );
   end

   cpt_merge #(
      .LANES (LANES)
   ) u_merge (
      .status     (lane_status),
      .query      (query),
      .resolved_a (resolved_a),
      .resolved_b (resolved_b),
      .resolved_c (resolved_c)
   );

   // Table update, applied only when the word is accepted.
   always_comb begin
      cmd.clear        = req_fire && word.block_start;
      cmd.kill_en      = req_fire && (is_move || (word.has_dst && word.last_part));
      cmd.kill_reg     = word.dst_reg;
      cmd.write_en     = req_fire && is_move && (resolved_a != word.dst_reg);
      cmd.write_reg    = word.dst_reg;
      cmd.write_origin = resolved_a;
   end

   // Result word: unused source slots read as zero.
   always_comb begin
      rsp_word = '0;
      if (is_move) begin
         rsp_word.res_a = resolved_a;
         rsp_word.drop  = (resolved_a == word.dst_reg);
      end else begin
         if (word.src_count > 2'd0) begin
            rsp_word.res_a = resolved_a;
         end
         if (word.src_count > 2'd1) begin
            rsp_word.res_b = resolved_b;
         end
         if (word.src_count > 2'd2) begin
            rsp_word.res_c = resolved_c;
         end
      end
   end

   // Output register; a new word enters as the held one leaves.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_word;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // No result is pending right after reset.
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result pending after reset");

   // Every accepted word yields a result in the next cycle.
   a_fire_result : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   // A dropped move carries only its first source.
   a_drop_move : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.drop) |->
      (rsp_data_ff.res_b == '0) && (rsp_data_ff.res_c == '0))
      else $error("dropped move carries extra sources");

   // A recorded move never maps a register onto itself.
   a_no_self_copy : assert property (@(posedge clock) disable iff (reset)
      cmd.write_en |-> (cmd.write_origin != cmd.write_reg))
      else $error("self copy recorded");

endmodule
